@@ rtl/gpf2d_pkg.sv @@
package gpf2d_pkg;

    // field and bus widths
    localparam int FIELD_W    = 32;
    localparam int S_TDATA_W  = 6 * FIELD_W;
    localparam int FORCE_W    = 64;
    localparam int M_TDATA_W  = 2 * FORCE_W;
    localparam int M_TUSER_W  = 2;
    localparam int COEFF_W    = 32;
    localparam int SHIFT_W    = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // default parameter values
    localparam int DEF_SQRT_FRAC_BITS = 16;
    localparam int DEF_POS_WIDTH      = 32;
    localparam int DEF_MASS_WIDTH     = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY_COEFF = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FORCE_SHIFT   = 2'd1;

    localparam logic [COEFF_W-1:0] COEFF_RESET = 32'd1;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 6'd0;

    // tuser bit positions on the result side
    localparam int TUSER_COINCIDENT = 0;
    localparam int TUSER_SATURATED  = 1;

endpackage

@@ rtl/gravity_pair_force_2d_unit.sv @@
// Pairwise 2-D gravity force, fully pipelined.
// Path: deltas, squares and mass product, root load, bit-per-stage square root (RFW stages),
//   partial-product sum and divider load, bit-per-stage divider (NUMW stages), output register.
// Throughput: one word per cycle while the skid entry is empty; a two-entry output register/skid
//   takes the word that arrives at a stalled output, and holds the input not ready until it drains.
// Reset: synchronous active low; clears valid bits, resets gravity_coeff to 1, force_shift to 0.
module gravity_pair_force_2d_unit #(
    parameter int SQRT_FRAC_BITS = gpf2d_pkg::DEF_SQRT_FRAC_BITS,
    parameter int POS_WIDTH      = gpf2d_pkg::DEF_POS_WIDTH,
    parameter int MASS_WIDTH     = gpf2d_pkg::DEF_MASS_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [gpf2d_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [gpf2d_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // self_x, self_y, self_mass, other_x, other_y, other_mass (32 bits each)
    input  logic [gpf2d_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // force_x [63:0], force_y [127:64]
    output logic [gpf2d_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // coincident [0], saturated [1]
    output logic [gpf2d_pkg::M_TUSER_W-1:0]     m_axis_tuser
);
    import gpf2d_pkg::*;

    localparam int PW   = POS_WIDTH;
    localparam int MW   = MASS_WIDTH;
    localparam int FB   = SQRT_FRAC_BITS;
    localparam int AW   = PW + 1;               // |d|
    localparam int R2W  = 2 * PW + 2;           // r^2
    localparam int SQW  = R2W + 2 * FB;         // r^2 scaled for the root
    localparam int RFW  = SQW / 2;              // r with FB fraction bits
    localparam int RMW  = RFW + 2;              // root remainder
    localparam int CMW  = COEFF_W + MW;         // coeff*m1
    localparam int BW   = COEFF_W + 2 * MW;     // coeff*m1*m2
    localparam int DENW = R2W + RFW;            // r^2 * rf
    localparam int NUMW = BW + AW + FB;         // base*|d| << FB
    localparam int QEW  = (NUMW > FORCE_W) ? NUMW : FORCE_W + 1;
    localparam int CK   = 32;                   // multiplier chunk
    localparam int PPW  = 2 * CK;
    localparam int ND_A = (R2W + CK - 1) / CK;
    localparam int ND_B = (RFW + CK - 1) / CK;
    localparam int NN_A = (BW + CK - 1) / CK;
    localparam int NN_B = (AW + CK - 1) / CK;

    // ---------------------------------------------------------------- config
    logic [COEFF_W-1:0] r_coeff;
    logic [SHIFT_W-1:0] r_shift;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coeff <= COEFF_RESET;
            r_shift <= SHIFT_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_GRAVITY_COEFF: r_coeff <= i_cfg_data[COEFF_W-1:0];
                CFG_FORCE_SHIFT:   r_shift <= i_cfg_data[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    // global advance: the pipeline moves unless the skid entry is occupied
    logic r_skid_v;
    logic en;
    assign en            = !r_skid_v;
    assign s_axis_tready = en;

    // ---------------------------------------------------------------- stage 1: deltas
    logic signed [PW-1:0] n_sx, n_sy, n_ox, n_oy;
    logic        [MW-1:0] n_m1, n_m2;
    logic signed [AW-1:0] n_dx, n_dy;
    logic        [AW-1:0] n_ax, n_ay;
    logic       [CMW-1:0] n_cm;

    assign n_sx = s_axis_tdata[0 +: PW];
    assign n_sy = s_axis_tdata[FIELD_W +: PW];
    assign n_m1 = s_axis_tdata[2 * FIELD_W +: MW];
    assign n_ox = s_axis_tdata[3 * FIELD_W +: PW];
    assign n_oy = s_axis_tdata[4 * FIELD_W +: PW];
    assign n_m2 = s_axis_tdata[5 * FIELD_W +: MW];
    assign n_dx = AW'(n_ox) - AW'(n_sx);
    assign n_dy = AW'(n_oy) - AW'(n_sy);
    assign n_ax = n_dx[AW-1] ? AW'(-n_dx) : AW'(n_dx);
    assign n_ay = n_dy[AW-1] ? AW'(-n_dy) : AW'(n_dy);
    assign n_cm = CMW'(r_coeff) * CMW'(n_m1);

    logic           r_s1_v, r_s1_negx, r_s1_negy, r_s1_coinc;
    logic  [AW-1:0] r_s1_ax, r_s1_ay;
    logic [CMW-1:0] r_s1_cm;
    logic  [MW-1:0] r_s1_m2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (en) begin
            r_s1_v <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_ax    <= n_ax;
            r_s1_ay    <= n_ay;
            r_s1_negx  <= n_dx[AW-1];
            r_s1_negy  <= n_dy[AW-1];
            r_s1_coinc <= (n_dx == '0) && (n_dy == '0);
            r_s1_cm    <= n_cm;
            r_s1_m2    <= n_m2;
        end
    end

    // ---------------------------------------------------------------- stage 2: squares, mass product
    logic              r_s2_v, r_s2_negx, r_s2_negy, r_s2_coinc;
    logic [2*AW-1:0]   r_s2_axx, r_s2_ayy;
    logic [COEFF_W+MW-1:0] r_s2_cmlo;
    logic [2*MW-1:0]   r_s2_cmhi;
    logic  [AW-1:0]    r_s2_ax, r_s2_ay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (en) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_axx   <= (2*AW)'(r_s1_ax) * (2*AW)'(r_s1_ax);
            r_s2_ayy   <= (2*AW)'(r_s1_ay) * (2*AW)'(r_s1_ay);
            r_s2_cmlo  <= (COEFF_W+MW)'(r_s1_cm[COEFF_W-1:0]) * (COEFF_W+MW)'(r_s1_m2);
            r_s2_cmhi  <= (2*MW)'(r_s1_cm[CMW-1:COEFF_W]) * (2*MW)'(r_s1_m2);
            r_s2_ax    <= r_s1_ax;
            r_s2_ay    <= r_s1_ay;
            r_s2_negx  <= r_s1_negx;
            r_s2_negy  <= r_s1_negy;
            r_s2_coinc <= r_s1_coinc;
        end
    end

    // ---------------------------------------------------------------- square root, one bit per stage
    // entry 0 is loaded with r^2 and base; entry RFW holds rf
    logic           r_sq_v     [0:RFW];
    logic           r_sq_negx  [0:RFW];
    logic           r_sq_negy  [0:RFW];
    logic           r_sq_coinc [0:RFW];
    logic [RMW-1:0] r_sq_rem   [0:RFW];
    logic [RFW-1:0] r_sq_root  [0:RFW];
    logic [R2W-1:0] r_sq_r2    [0:RFW];
    logic  [BW-1:0] r_sq_base  [0:RFW];
    logic  [AW-1:0] r_sq_ax    [0:RFW];
    logic  [AW-1:0] r_sq_ay    [0:RFW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v[0] <= 1'b0;
        end else if (en) begin
            r_sq_v[0] <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq_r2[0]    <= R2W'(r_s2_axx) + R2W'(r_s2_ayy);
            r_sq_base[0]  <= (BW'(r_s2_cmhi) << COEFF_W) + BW'(r_s2_cmlo);
            r_sq_rem[0]   <= '0;
            r_sq_root[0]  <= '0;
            r_sq_ax[0]    <= r_s2_ax;
            r_sq_ay[0]    <= r_s2_ay;
            r_sq_negx[0]  <= r_s2_negx;
            r_sq_negy[0]  <= r_s2_negy;
            r_sq_coinc[0] <= r_s2_coinc;
        end
    end

    for (genvar k = 0; k < RFW; k++) begin : g_sqrt
        logic [SQW-1:0] n_scaled;
        logic [RMW-1:0] n_rs, n_trial;
        logic           n_ge;

        assign n_scaled = SQW'(r_sq_r2[k]) << (2 * FB);
        assign n_rs     = {r_sq_rem[k][RMW-3:0], n_scaled[SQW-1-2*k -: 2]};
        assign n_trial  = (RMW'(r_sq_root[k]) << 2) | RMW'(1);
        assign n_ge     = (n_rs >= n_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[k+1] <= 1'b0;
            end else if (en) begin
                r_sq_v[k+1] <= r_sq_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq_rem[k+1]   <= n_ge ? n_rs - n_trial : n_rs;
                r_sq_root[k+1]  <= {r_sq_root[k][RFW-2:0], n_ge};
                r_sq_r2[k+1]    <= r_sq_r2[k];
                r_sq_base[k+1]  <= r_sq_base[k];
                r_sq_ax[k+1]    <= r_sq_ax[k];
                r_sq_ay[k+1]    <= r_sq_ay[k];
                r_sq_negx[k+1]  <= r_sq_negx[k];
                r_sq_negy[k+1]  <= r_sq_negy[k];
                r_sq_coinc[k+1] <= r_sq_coinc[k];
            end
        end
    end

    // ---------------------------------------------------------------- M1: 32x32 partial products
    logic           r_m1_v, r_m1_negx, r_m1_negy, r_m1_coinc;
    logic [PPW-1:0] r_m1_ppd [ND_A][ND_B];
    logic [PPW-1:0] r_m1_ppx [NN_A][NN_B];
    logic [PPW-1:0] r_m1_ppy [NN_A][NN_B];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_v <= 1'b0;
        end else if (en) begin
            r_m1_v <= r_sq_v[RFW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < ND_A; i++) begin
                for (int j = 0; j < ND_B; j++) begin
                    r_m1_ppd[i][j] <= PPW'(CK'(r_sq_r2[RFW] >> (CK * i)))
                                    * PPW'(CK'(r_sq_root[RFW] >> (CK * j)));
                end
            end
            for (int i = 0; i < NN_A; i++) begin
                for (int j = 0; j < NN_B; j++) begin
                    r_m1_ppx[i][j] <= PPW'(CK'(r_sq_base[RFW] >> (CK * i)))
                                    * PPW'(CK'(r_sq_ax[RFW] >> (CK * j)));
                    r_m1_ppy[i][j] <= PPW'(CK'(r_sq_base[RFW] >> (CK * i)))
                                    * PPW'(CK'(r_sq_ay[RFW] >> (CK * j)));
                end
            end
            r_m1_negx  <= r_sq_negx[RFW];
            r_m1_negy  <= r_sq_negy[RFW];
            r_m1_coinc <= r_sq_coinc[RFW];
        end
    end

    // ---------------------------------------------------------------- M2: sum partial products
    logic [DENW-1:0] n_den;
    logic [NUMW-1:0] n_numx, n_numy;

    always_comb begin
        n_den  = '0;
        n_numx = '0;
        n_numy = '0;
        for (int i = 0; i < ND_A; i++) begin
            for (int j = 0; j < ND_B; j++) begin
                n_den = n_den + (DENW'(r_m1_ppd[i][j]) << (CK * (i + j)));
            end
        end
        for (int i = 0; i < NN_A; i++) begin
            for (int j = 0; j < NN_B; j++) begin
                n_numx = n_numx + (NUMW'(r_m1_ppx[i][j]) << (CK * (i + j)));
                n_numy = n_numy + (NUMW'(r_m1_ppy[i][j]) << (CK * (i + j)));
            end
        end
        n_numx = n_numx << FB;
        n_numy = n_numy << FB;
    end

    // ---------------------------------------------------------------- divider, one quotient bit per stage
    // nq starts as the numerator and shifts left, quotient bits entering at the bottom
    logic            r_dv_v     [0:NUMW];
    logic            r_dv_negx  [0:NUMW];
    logic            r_dv_negy  [0:NUMW];
    logic            r_dv_coinc [0:NUMW];
    logic [DENW-1:0] r_dv_den   [0:NUMW];
    logic [DENW-1:0] r_dv_remx  [0:NUMW];
    logic [DENW-1:0] r_dv_remy  [0:NUMW];
    logic [NUMW-1:0] r_dv_nqx   [0:NUMW];
    logic [NUMW-1:0] r_dv_nqy   [0:NUMW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v[0] <= 1'b0;
        end else if (en) begin
            r_dv_v[0] <= r_m1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv_den[0]   <= n_den;
            r_dv_remx[0]  <= '0;
            r_dv_remy[0]  <= '0;
            r_dv_nqx[0]   <= n_numx;
            r_dv_nqy[0]   <= n_numy;
            r_dv_negx[0]  <= r_m1_negx;
            r_dv_negy[0]  <= r_m1_negy;
            r_dv_coinc[0] <= r_m1_coinc;
        end
    end

    for (genvar k = 0; k < NUMW; k++) begin : g_div
        logic [DENW:0] n_rsx, n_rsy, n_dd;
        logic          n_gex, n_gey;

        assign n_dd  = (DENW+1)'(r_dv_den[k]);
        assign n_rsx = {r_dv_remx[k], r_dv_nqx[k][NUMW-1]};
        assign n_rsy = {r_dv_remy[k], r_dv_nqy[k][NUMW-1]};
        assign n_gex = (n_rsx >= n_dd);
        assign n_gey = (n_rsy >= n_dd);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[k+1] <= 1'b0;
            end else if (en) begin
                r_dv_v[k+1] <= r_dv_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv_remx[k+1]  <= DENW'(n_gex ? n_rsx - n_dd : n_rsx);
                r_dv_remy[k+1]  <= DENW'(n_gey ? n_rsy - n_dd : n_rsy);
                r_dv_nqx[k+1]   <= {r_dv_nqx[k][NUMW-2:0], n_gex};
                r_dv_nqy[k+1]   <= {r_dv_nqy[k][NUMW-2:0], n_gey};
                r_dv_den[k+1]   <= r_dv_den[k];
                r_dv_negx[k+1]  <= r_dv_negx[k];
                r_dv_negy[k+1]  <= r_dv_negy[k];
                r_dv_coinc[k+1] <= r_dv_coinc[k];
            end
        end
    end

    // ---------------------------------------------------------------- shift, sign, saturate
    // returns {clipped, value}
    function automatic logic [FORCE_W:0] sat_comp(input logic [NUMW-1:0]    q,
                                                  input logic               neg,
                                                  input logic [SHIFT_W-1:0] sh);
        logic [QEW-1:0]     qe;
        logic               big;
        logic [FORCE_W-1:0] lo;
        logic [FORCE_W-1:0] minv;
        logic [FORCE_W:0]   res;
        qe   = QEW'(q) >> sh;
        big  = |qe[QEW-1:FORCE_W];
        lo   = qe[FORCE_W-1:0];
        minv = {1'b1, {(FORCE_W-1){1'b0}}};
        if (neg) begin
            if (big || lo > minv) res = {1'b1, minv};
            else                  res = {1'b0, FORCE_W'(-lo)};
        end else begin
            if (big || lo[FORCE_W-1]) res = {1'b1, ~minv};
            else                      res = {1'b0, lo};
        end
        return res;
    endfunction

    logic [FORCE_W:0]   n_cx, n_cy;
    logic [FORCE_W-1:0] n_fx, n_fy;
    logic               n_sat, n_coinc, n_last_v;

    assign n_cx     = sat_comp(r_dv_nqx[NUMW], r_dv_negx[NUMW], r_shift);
    assign n_cy     = sat_comp(r_dv_nqy[NUMW], r_dv_negy[NUMW], r_shift);
    assign n_coinc  = r_dv_coinc[NUMW];
    assign n_last_v = r_dv_v[NUMW];
    assign n_fx     = n_coinc ? '0 : n_cx[FORCE_W-1:0];
    assign n_fy     = n_coinc ? '0 : n_cy[FORCE_W-1:0];
    assign n_sat    = !n_coinc && (n_cx[FORCE_W] || n_cy[FORCE_W]);

    // ---------------------------------------------------------------- output register and skid
    logic               r_out_v, r_out_coinc, r_out_sat, r_skid_coinc, r_skid_sat;
    logic [FORCE_W-1:0] r_out_fx, r_out_fy, r_skid_fx, r_skid_fy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (m_axis_tready) begin
                r_skid_v <= 1'b0;
            end
        end else if (!r_out_v || m_axis_tready) begin
            r_out_v <= n_last_v;
        end else if (n_last_v) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (m_axis_tready) begin
                r_out_fx    <= r_skid_fx;
                r_out_fy    <= r_skid_fy;
                r_out_coinc <= r_skid_coinc;
                r_out_sat   <= r_skid_sat;
            end
        end else if (!r_out_v || m_axis_tready) begin
            r_out_fx    <= n_fx;
            r_out_fy    <= n_fy;
            r_out_coinc <= n_coinc;
            r_out_sat   <= n_sat;
        end else begin
            r_skid_fx    <= n_fx;
            r_skid_fy    <= n_fy;
            r_skid_coinc <= n_coinc;
            r_skid_sat   <= n_sat;
        end
    end

    assign m_axis_tvalid                    = r_out_v;
    assign m_axis_tdata                     = {r_out_fy, r_out_fx};
    assign m_axis_tuser[TUSER_COINCIDENT]   = r_out_coinc;
    assign m_axis_tuser[TUSER_SATURATED]    = r_out_sat;

endmodule

@@ rtl/gpf2d_checker.sv @@
module gpf2d_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    // force_x [63:0], force_y [127:64]
    input logic [gpf2d_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // coincident [0], saturated [1]
    input logic [gpf2d_pkg::M_TUSER_W-1:0] m_axis_tuser
);
    import gpf2d_pkg::*;

    localparam logic [FORCE_W-1:0] F_MIN = {1'b1, {(FORCE_W-1){1'b0}}};
    localparam logic [FORCE_W-1:0] F_MAX = ~F_MIN;

    // coincident bodies give zero force and no clipping
    a_coinc_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[TUSER_COINCIDENT]
        |-> m_axis_tdata == '0 && !m_axis_tuser[TUSER_SATURATED])
        else $error("coincident word with nonzero force or saturation");

    // a clipped word has a component at a range limit
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[TUSER_SATURATED]
        |-> m_axis_tdata[FORCE_W-1:0] == F_MAX || m_axis_tdata[FORCE_W-1:0] == F_MIN
         || m_axis_tdata[2*FORCE_W-1:FORCE_W] == F_MAX
         || m_axis_tdata[2*FORCE_W-1:FORCE_W] == F_MIN)
        else $error("saturated word without a clipped component");

    // input backpressure only follows a stalled output word
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> $past(m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without output backpressure");

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready
        |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output word changed while stalled");

endmodule

bind gravity_pair_force_2d_unit gpf2d_checker u_gpf2d_checker (.*);

@@ dv/tb_gravity_pair_force_2d_unit.sv @@
module tb_gravity_pair_force_2d_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import gpf2d_pkg::*;

    localparam int PIPE_LAT = 200;
    localparam int FRAC     = DEF_SQRT_FRAC_BITS;
    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_B = 2'd3;

    typedef struct packed {
        logic [31:0] om;
        logic [31:0] oy;
        logic [31:0] ox;
        logic [31:0] sm;
        logic [31:0] sy;
        logic [31:0] sx;
    } body_pair_t;

    typedef struct {
        logic [63:0] fx;
        logic [63:0] fy;
        logic        coin;
        logic        sat;
    } pull_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic [M_TUSER_W-1:0]  m_axis_tuser;

    gravity_pair_force_2d_unit uut (.*);

    // local copy of the registers
    logic [COEFF_W-1:0] coeff_now;
    logic [SHIFT_W-1:0] shift_now;

    pull_t pull_q[$];
    int    n_pairs, n_pulls, n_fail, n_coin, n_sat;
    bit    calm;       // no random idling on either side
    bit    rx_hold;    // receiver long hold-off request

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("gravity_pair_force_2d_unit: mismatch");
        $finish;
    end

    // one force component: magnitude quotient, shift, sign, clip
    function automatic logic [63:0] pull_axis(input logic [255:0] base, input logic [33:0] d,
                                              input logic [255:0] den, inout logic sat);
        logic [255:0] mag, q;
        mag = d[33] ? 256'(-$signed(d)) : 256'(d);
        q = ((base * mag) << FRAC) / den;
        q = q >> shift_now;
        if (d[33]) begin
            if (q > (256'd1 << 63)) begin
                sat = 1'b1;
                return 64'h8000_0000_0000_0000;
            end
            return -q[63:0];
        end
        if (q > ((256'd1 << 63) - 1)) begin
            sat = 1'b1;
            return 64'h7fff_ffff_ffff_ffff;
        end
        return q[63:0];
    endfunction

    function automatic pull_t calc_pull(input body_pair_t p);
        logic [33:0]  dx, dy;
        logic [255:0] ax, ay, r2, scaled, rt, trial, den, base;
        pull_t r;
        dx = {{2{p.ox[31]}}, p.ox} - {{2{p.sx[31]}}, p.sx};
        dy = {{2{p.oy[31]}}, p.oy} - {{2{p.sy[31]}}, p.sy};
        r.sat = 1'b0;
        r.coin = 1'b0;
        if (dx == 0 && dy == 0) begin
            r.fx = '0;
            r.fy = '0;
            r.coin = 1'b1;
            return r;
        end
        ax = dx[33] ? 256'(-$signed(dx)) : 256'(dx);
        ay = dy[33] ? 256'(-$signed(dy)) : 256'(dy);
        r2 = ax * ax + ay * ay;
        scaled = r2 << (2 * FRAC);
        // bitwise floor square root
        rt = '0;
        for (int b = 63; b >= 0; b--) begin
            trial = rt | (256'd1 << b);
            if (trial * trial <= scaled) rt = trial;
        end
        den = r2 * rt;
        base = 256'(coeff_now) * 256'(p.sm) * 256'(p.om);
        r.fx = pull_axis(base, dx, den, r.sat);
        r.fy = pull_axis(base, dy, den, r.sat);
        return r;
    endfunction

    // send one body pair and queue its force
    task automatic send_pair(input body_pair_t p);
        bit rdy;
        pull_q.push_back(calc_pull(p));
        s_axis_tdata <= p;
        s_axis_tvalid <= 1'b1;
        do begin
            @(negedge i_clk);
            rdy = s_axis_tready;
            @(posedge i_clk);
        end while (!rdy);
        n_pairs++;
        if (!calm && $urandom_range(99) < 11) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic stop_sending();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (pull_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        bit rdy;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        i_cfg_valid <= 1'b1;
        do begin
            @(negedge i_clk);
            rdy = o_cfg_ready;
            @(posedge i_clk);
        end while (!rdy);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_GRAVITY_COEFF: coeff_now = val;
            CFG_FORCE_SHIFT:   shift_now = val[SHIFT_W-1:0];
            default: ;
        endcase
    endtask

    // registers change only with the pipe empty
    task automatic set_regs(input logic [31:0] c, input logic [31:0] s);
        stop_sending();
        wait_drained();
        write_reg(CFG_GRAVITY_COEFF, c);
        write_reg(CFG_FORCE_SHIFT, s);
    endtask

    function automatic body_pair_t mk(input int sx, input int sy, input logic [31:0] sm,
                                      input int ox, input int oy, input logic [31:0] om);
        body_pair_t p;
        p.sx = sx; p.sy = sy; p.sm = sm; p.ox = ox; p.oy = oy; p.om = om;
        return p;
    endfunction

    function automatic body_pair_t rand_pair();
        body_pair_t p;
        int kind;
        p.sx = $urandom;
        p.sy = $urandom;
        p.sm = $urandom >> $urandom_range(31);
        p.om = $urandom >> $urandom_range(31);
        kind = $urandom_range(99);
        if (kind < 4) begin
            p.ox = p.sx;
            p.oy = p.sy;
        end else if (kind < 50) begin
            // nearby body: offsets of varied size and either sign
            p.ox = p.sx + 32'($signed($urandom) >>> $urandom_range(31));
            p.oy = p.sy + 32'($signed($urandom) >>> $urandom_range(31));
        end else if (kind < 60) begin
            p.ox = p.sx + 32'($signed($urandom) >>> $urandom_range(31));
            p.oy = p.sy;
        end else begin
            p.ox = $urandom;
            p.oy = $urandom;
        end
        return p;
    endfunction

    // result checker: a word is taken at the edge after this sample
    always @(negedge i_clk) begin
        pull_t e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_pulls++;
            if (pull_q.size() == 0) begin
                n_fail++;
                $display("%0t: unexpected result %h/%b", $time, m_axis_tdata, m_axis_tuser);
            end else begin
                e = pull_q.pop_front();
                n_coin += e.coin;
                n_sat += e.sat;
                if (m_axis_tdata[FORCE_W-1:0] !== e.fx) begin
                    n_fail++;
                    $display("%0t: force_x exp %h got %h", $time, e.fx,
                             m_axis_tdata[FORCE_W-1:0]);
                end
                if (m_axis_tdata[M_TDATA_W-1:FORCE_W] !== e.fy) begin
                    n_fail++;
                    $display("%0t: force_y exp %h got %h", $time, e.fy,
                             m_axis_tdata[M_TDATA_W-1:FORCE_W]);
                end
                if (m_axis_tuser[TUSER_COINCIDENT] !== e.coin) begin
                    n_fail++;
                    $display("%0t: coincident exp %b got %b", $time, e.coin,
                             m_axis_tuser[TUSER_COINCIDENT]);
                end
                if (m_axis_tuser[TUSER_SATURATED] !== e.sat) begin
                    n_fail++;
                    $display("%0t: saturated exp %b got %b", $time, e.sat,
                             m_axis_tuser[TUSER_SATURATED]);
                end
            end
        end
    end

    // receiver ready: random stalls, or a long counted hold-off
    always @(posedge i_clk) begin
        int held;
        if (rx_hold) begin
            m_axis_tready <= 1'b0;
            held++;
            if (held >= 600) begin
                rx_hold <= 1'b0;
                held = 0;
            end
        end else begin
            m_axis_tready <= calm || ($urandom_range(99) >= 11);
        end
    end

    task automatic test_directed();
        // reset values first: coeff 1, shift 0
        send_pair(mk(0, 0, 32'd5, 0, 0, 32'd7));
        send_pair(mk(-2147483648, -2147483648, '1, -2147483648, -2147483648, '1));
        send_pair(mk(0, 0, 32'd1, 1, 0, 32'd1));
        send_pair(mk(0, 0, 32'd1, 0, -1, 32'd1));
        send_pair(mk(0, 0, 32'd1000, -3, 4, 32'd1000));
        send_pair(mk(-2147483648, 2147483647, '1, 2147483647, -2147483648, '1));
        send_pair(mk(2147483647, 0, 32'd0, -2147483648, 0, '1));
        send_pair(mk(10, 10, '1, 11, 10, '1));
        // largest coefficient, big masses at unit offsets on each axis: clipping both ways
        set_regs('1, 32'hffff_ffc0);
        send_pair(mk(0, 0, '1, 1, -1, '1));
        send_pair(mk(5, 5, '1, 4, 6, '1));
        send_pair(mk(0, 0, '1, -2147483648, 2147483647, '1));
        send_pair(mk(7, 7, '1, 7, 7, '1));
        // widest shift
        set_regs('1, 32'd63);
        send_pair(mk(0, 0, '1, 1, 1, '1));
        send_pair(mk(0, 0, '1, -1, -1, '1));
        send_pair(mk(0, 0, 32'd3, 100, -100, 32'd9));
        // unmapped indexes must leave the registers alone
        set_regs(32'd0, 32'd5);
        write_reg(CFG_UNMAPPED_A, '1);
        write_reg(CFG_UNMAPPED_B, 32'h1234_5678);
        send_pair(mk(0, 0, '1, 1, 0, '1));
        send_pair(mk(3, -3, 32'd8, 3, -3, 32'd8));
    endtask

    task automatic test_random(input logic [31:0] c, input logic [31:0] s, input int cnt);
        set_regs(c, s);
        repeat (cnt) send_pair(rand_pair());
    endtask

    // receiver holds off while pairs keep coming; input must stall
    task automatic test_backpressure();
        rx_hold <= 1'b1;
        repeat (400) send_pair(rand_pair());
    endtask

    // sender waits for the pipe to empty, then resumes
    task automatic test_pause();
        repeat (30) send_pair(rand_pair());
        stop_sending();
        wait_drained();
        repeat (30) send_pair(rand_pair());
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        coeff_now = COEFF_RESET;
        shift_now = SHIFT_RESET;
        calm = 1'b0;
        rx_hold = 1'b0;
        n_pairs = 0; n_pulls = 0; n_fail = 0; n_coin = 0; n_sat = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(32'd1, 32'd0, 300);
        test_random($urandom, $urandom_range(63), 300);
        test_random($urandom >> 16, 32'd20, 250);
        calm = 1'b1;
        test_random($urandom, 32'd40, 250);
        calm = 1'b0;
        test_random('1, 32'd63, 200);
        test_backpressure();
        test_pause();
        test_random(32'd0, 32'd0, 100);

        stop_sending();
        wait_drained();
        repeat (PIPE_LAT + 50) @(posedge i_clk);
        if (pull_q.size() != 0) begin
            n_fail++;
            $display("%0t: %0d results never arrived", $time, pull_q.size());
        end
        $display("sent %0d body pairs, checked %0d forces", n_pairs, n_pulls);
        $display("%0d coincident, %0d clipped, across several register settings and extremes",
                 n_coin, n_sat);
        if (n_fail == 0) begin
            $display("gravity_pair_force_2d_unit: match");
        end else begin
            $display("gravity_pair_force_2d_unit: mismatch");
        end
        $finish;
    end

endmodule
